// ----- src/crbm_pkg.sv -----
// Shared types and constants for the controller report blend merger.
package crbm_pkg;

    localparam logic       ACT_REPORT     = 1'b0;
    localparam logic       ACT_DISCONNECT = 1'b1;
    localparam logic       MODE_BLEND     = 1'b0;
    localparam logic       MODE_LATEST    = 1'b1;
    localparam logic [7:0] CENTER         = 8'd128;
    localparam logic [31:0] STICK_NEUTRAL = 32'h8080_8080;
    localparam logic [7:0] INST_NONE      = 8'hFF;

    typedef struct packed {
        logic        action;
        logic        store;
        logic [7:0]  addr;
        logic [7:0]  inst;
        logic [31:0] buttons;
        logic [31:0] keys;
        logic [31:0] sticks;
        logic [15:0] triggers;
        logic [7:0]  delta_x;
        logic [7:0]  delta_y;
    } cmd_t;

    typedef struct packed {
        logic        need_claim;
        logic        wrote;
        logic        have_lead;
        logic [31:0] buttons;
        logic [31:0] keys;
        logic [31:0] sticks;
        logic [15:0] triggers;
        logic [7:0]  lead_addr;
        logic [7:0]  lead_inst;
    } acc_t;

    typedef struct packed {
        logic        dropped;
        logic [31:0] buttons;
        logic [31:0] keys;
        logic [31:0] sticks;
        logic [15:0] triggers;
        logic [7:0]  delta_x;
        logic [7:0]  delta_y;
        logic [7:0]  lead_addr;
        logic [7:0]  lead_inst;
    } res_t;

endpackage

// ----- src/crbm_if.sv -----
// Valid/ready channel interfaces for report words and merged words.
interface crbm_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         bus_addr;
    logic signed [7:0]  instance_req;
    logic [31:0]        buttons;
    logic [31:0]        keys;
    logic [31:0]        stick_axes;
    logic [15:0]        trigger_axes;
    logic [7:0]         delta_x;
    logic [7:0]         delta_y;

    modport source (output valid, action, bus_addr, instance_req, buttons, keys,
                    stick_axes, trigger_axes, delta_x, delta_y, input ready);
    modport sink   (input valid, action, bus_addr, instance_req, buttons, keys,
                    stick_axes, trigger_axes, delta_x, delta_y, output ready);
endinterface

interface crbm_out_if;
    logic               valid;
    logic               ready;
    logic               dropped;
    logic [31:0]        merged_buttons;
    logic [31:0]        merged_keys;
    logic [31:0]        merged_sticks;
    logic [15:0]        merged_triggers;
    logic [7:0]         merged_delta_x;
    logic [7:0]         merged_delta_y;
    logic [7:0]         lead_addr;
    logic signed [7:0]  lead_instance;

    modport source (output valid, dropped, merged_buttons, merged_keys, merged_sticks,
                    merged_triggers, merged_delta_x, merged_delta_y, lead_addr,
                    lead_instance, input ready);
    modport sink   (input valid, dropped, merged_buttons, merged_keys, merged_sticks,
                    merged_triggers, merged_delta_x, merged_delta_y, lead_addr,
                    lead_instance, output ready);
endinterface

// ----- src/controller_report_blend_merger.sv -----
// Top level: report intake, slot cell chain and merged word output register.
// Each accepted report word walks the slot cells in order with the blend token (the first
// cell also sees the slot match search); the blend is then registered and loaded into the
// output register once that register is empty or its word is taken. A new report word is
// taken in the cycle after the load, while the previous merged word may still wait for its
// sink, so a new word is taken only after the last one has reached the output register.
module controller_report_blend_merger #(
    parameter int SLOT_COUNT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    crbm_in_if.sink    report,
    crbm_out_if.source merged,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);
    import crbm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mode_reg;
    cmd_t       cmd_reg;
    res_t       res_reg, res_next;
    res_t       out_reg;
    logic       out_valid_reg, out_valid_next;

    logic [SLOT_COUNT:0]   tok;
    acc_t                  acc [SLOT_COUNT+1];
    acc_t                  acc_head;
    logic [SLOT_COUNT-1:0] match_vec;
    logic                  load_out;

    assign report.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        acc_head            = '0;
        acc_head.sticks     = STICK_NEUTRAL;
        acc_head.lead_inst  = INST_NONE;
        acc_head.need_claim = cmd_reg.store && !(|match_vec);
    end

    assign acc[0] = acc_head;
    assign tok[0] = (state_reg == ST_START);

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        crbm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd_reg),
            .tok_in  (tok[i]),
            .acc_in  (acc[i]),
            .tok_out (tok[i+1]),
            .acc_out (acc[i+1]),
            .match   (match_vec[i])
        );
    end

    always_comb
    begin
        res_next = res_reg;
        if (tok[SLOT_COUNT])
        begin
            res_next.dropped   = 1'b0;
            res_next.buttons   = acc[SLOT_COUNT].buttons;
            res_next.keys      = acc[SLOT_COUNT].keys;
            res_next.sticks    = acc[SLOT_COUNT].sticks;
            res_next.triggers  = acc[SLOT_COUNT].triggers;
            res_next.lead_addr = acc[SLOT_COUNT].lead_addr;
            res_next.lead_inst = acc[SLOT_COUNT].lead_inst;
            res_next.delta_x   = 8'd0;
            res_next.delta_y   = 8'd0;
            if (mode_reg == MODE_LATEST)
            begin
                if (cmd_reg.action == ACT_DISCONNECT)
                begin
                    res_next.buttons   = 32'd0;
                    res_next.keys      = 32'd0;
                    res_next.sticks    = STICK_NEUTRAL;
                    res_next.triggers  = 16'd0;
                    res_next.lead_addr = 8'd0;
                    res_next.lead_inst = INST_NONE;
                end
                else
                begin
                    res_next.buttons   = cmd_reg.buttons;
                    res_next.keys      = cmd_reg.keys;
                    res_next.sticks    = cmd_reg.sticks;
                    res_next.triggers  = cmd_reg.triggers;
                    res_next.lead_addr = cmd_reg.addr;
                    res_next.lead_inst = cmd_reg.inst;
                    res_next.delta_x   = cmd_reg.delta_x;
                    res_next.delta_y   = cmd_reg.delta_y;
                end
            end
            else if (cmd_reg.action == ACT_REPORT)
            begin
                if (acc[SLOT_COUNT].need_claim)
                    res_next.dropped = 1'b1;
                else
                begin
                    res_next.delta_x = cmd_reg.delta_x;
                    res_next.delta_y = cmd_reg.delta_y;
                end
            end
        end
    end

    assign load_out = (state_reg == ST_LOAD) && (!out_valid_reg || merged.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (merged.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (report.valid)
                    state_next = ST_START;
            end
            ST_START:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (tok[SLOT_COUNT])
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_out)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_BLEND;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report.valid && report.ready)
        begin
            cmd_reg.action   <= report.action;
            cmd_reg.store    <= (report.action == ACT_REPORT) && (mode_reg == MODE_BLEND);
            cmd_reg.addr     <= report.bus_addr;
            cmd_reg.inst     <= $unsigned(report.instance_req);
            cmd_reg.buttons  <= report.buttons;
            cmd_reg.keys     <= report.keys;
            cmd_reg.sticks   <= report.stick_axes;
            cmd_reg.triggers <= report.trigger_axes;
            cmd_reg.delta_x  <= report.delta_x;
            cmd_reg.delta_y  <= report.delta_y;
        end
        res_reg <= res_next;
        if (load_out)
            out_reg <= res_reg;
    end

    assign merged.valid           = out_valid_reg;
    assign merged.dropped         = out_reg.dropped;
    assign merged.merged_buttons  = out_reg.buttons;
    assign merged.merged_keys     = out_reg.keys;
    assign merged.merged_sticks   = out_reg.sticks;
    assign merged.merged_triggers = out_reg.triggers;
    assign merged.merged_delta_x  = out_reg.delta_x;
    assign merged.merged_delta_y  = out_reg.delta_y;
    assign merged.lead_addr       = out_reg.lead_addr;
    assign merged.lead_instance   = $signed(out_reg.lead_inst);

    // the chain is empty whenever a new word may be taken
    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !tok[SLOT_COUNT])
        else $error("token still in slot chain while idle");

    a_drop_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.dropped) |->
            (out_reg.delta_x == 8'd0 && out_reg.delta_y == 8'd0))
        else $error("dropped word carries mouse deltas");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && out_valid_reg && !merged.ready) |=>
            (state_reg == ST_LOAD && $stable(out_reg)))
        else $error("output overwritten while stalled");

    a_token_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |=> tok[1])
        else $error("token not launched into slot chain");

endmodule

// ----- src/crbm_cell.sv -----
// One slot cell: holds a device slot, updates it and folds it into the passing blend.
module crbm_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  crbm_pkg::cmd_t cmd,
    input  logic          tok_in,
    input  crbm_pkg::acc_t acc_in,
    output logic          tok_out,
    output crbm_pkg::acc_t acc_out,
    output logic          match
);
    import crbm_pkg::*;

    logic        active_reg,  active_next;
    logic [7:0]  addr_reg,    addr_next;
    logic [7:0]  inst_reg,    inst_next;
    logic [31:0] buttons_reg, buttons_next;
    logic [31:0] keys_reg,    keys_next;
    logic [31:0] sticks_reg,  sticks_next;
    logic [15:0] trig_reg,    trig_next;
    logic        tok_reg;
    acc_t        acc_reg,     acc_next;

    function automatic logic [7:0] axis_dist(input logic [7:0] v);
        begin
            axis_dist = (v >= CENTER) ? (v - CENTER) : (CENTER - v);
        end
    endfunction

    assign match = active_reg && (addr_reg == cmd.addr) && (inst_reg == cmd.inst);

    always_comb
    begin
        active_next  = active_reg;
        addr_next    = addr_reg;
        inst_next    = inst_reg;
        buttons_next = buttons_reg;
        keys_next    = keys_reg;
        sticks_next  = sticks_reg;
        trig_next    = trig_reg;
        acc_next     = acc_in;
        if (tok_in)
        begin
            if (cmd.action == ACT_DISCONNECT && match)
            begin
                active_next  = 1'b0;
                addr_next    = 8'd0;
                inst_next    = INST_NONE;
                buttons_next = 32'd0;
                keys_next    = 32'd0;
                sticks_next  = STICK_NEUTRAL;
                trig_next    = 16'd0;
            end
            else if (cmd.store &&
                     ((match && !acc_in.wrote) || (acc_in.need_claim && !active_reg)))
            begin
                active_next  = 1'b1;
                addr_next    = cmd.addr;
                inst_next    = cmd.inst;
                buttons_next = cmd.buttons;
                keys_next    = cmd.keys;
                sticks_next  = cmd.sticks;
                trig_next    = cmd.triggers;
                acc_next.wrote      = 1'b1;
                acc_next.need_claim = 1'b0;
            end
            if (active_next)
            begin
                acc_next.buttons = acc_in.buttons | buttons_next;
                acc_next.keys    = acc_in.keys | keys_next;
                for (int b = 0; b < 4; b++)
                begin
                    if (axis_dist(sticks_next[b*8 +: 8]) > axis_dist(acc_in.sticks[b*8 +: 8]))
                        acc_next.sticks[b*8 +: 8] = sticks_next[b*8 +: 8];
                end
                for (int b = 0; b < 2; b++)
                begin
                    if (trig_next[b*8 +: 8] > acc_in.triggers[b*8 +: 8])
                        acc_next.triggers[b*8 +: 8] = trig_next[b*8 +: 8];
                end
                if (!acc_in.have_lead)
                begin
                    acc_next.have_lead = 1'b1;
                    acc_next.lead_addr = addr_next;
                    acc_next.lead_inst = inst_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            addr_reg    <= 8'd0;
            inst_reg    <= INST_NONE;
            buttons_reg <= 32'd0;
            keys_reg    <= 32'd0;
            sticks_reg  <= STICK_NEUTRAL;
            trig_reg    <= 16'd0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            addr_reg    <= addr_next;
            inst_reg    <= inst_next;
            buttons_reg <= buttons_next;
            keys_reg    <= keys_next;
            sticks_reg  <= sticks_next;
            trig_reg    <= trig_next;
            tok_reg     <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

// ----- tb/sv/controller_report_blend_merger_tb.sv -----
// Testbench for the controller report blend merger: directed and random report words, scoreboard.
module controller_report_blend_merger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crbm_pkg::*;

    localparam int SLOT_COUNT     = 8;
    localparam int POOL_SIZE      = 12;
    localparam int SETTLE_CYCLES  = SLOT_COUNT + 6;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic        action;
        logic [7:0]  addr;
        logic [7:0]  inst;
        logic [31:0] buttons;
        logic [31:0] keys;
        logic [31:0] sticks;
        logic [15:0] triggers;
        logic [7:0]  delta_x;
        logic [7:0]  delta_y;
    } report_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    crbm_in_if  rpt_if ();
    crbm_out_if mrg_if ();

    controller_report_blend_merger #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (rpt_if),
        .merged      (mrg_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // slot table as the block should hold it
    logic        seat_used  [SLOT_COUNT];
    logic [7:0]  seat_addr  [SLOT_COUNT];
    logic [7:0]  seat_inst  [SLOT_COUNT];
    logic [31:0] seat_btn   [SLOT_COUNT];
    logic [31:0] seat_key   [SLOT_COUNT];
    logic [31:0] seat_stick [SLOT_COUNT];
    logic [15:0] seat_trig  [SLOT_COUNT];
    logic        mode_now;

    logic [7:0]  pool_addr [POOL_SIZE];
    logic [7:0]  pool_inst [POOL_SIZE];

    res_t merged_due_q [$];
    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;

    function automatic void clear_seat(input int i);
        seat_used[i]  = 1'b0;
        seat_addr[i]  = 8'd0;
        seat_inst[i]  = INST_NONE;
        seat_btn[i]   = 32'd0;
        seat_key[i]   = 32'd0;
        seat_stick[i] = STICK_NEUTRAL;
        seat_trig[i]  = 16'd0;
    endfunction

    function automatic logic [7:0] axis_distance(input logic [7:0] v);
        return (v >= CENTER) ? (v - CENTER) : (CENTER - v);
    endfunction

    function automatic res_t neutral_word();
        res_t r;
        r           = '0;
        r.sticks    = STICK_NEUTRAL;
        r.lead_inst = INST_NONE;
        return r;
    endfunction

    function automatic res_t blend_seats();
        res_t       r;
        logic       first;
        logic [7:0] cur;
        logic [7:0] dev;
        r     = neutral_word();
        first = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (seat_used[i])
            begin
                r.buttons |= seat_btn[i];
                r.keys    |= seat_key[i];
                for (int b = 0; b < 4; b++)
                begin
                    cur = r.sticks[b*8 +: 8];
                    dev = seat_stick[i][b*8 +: 8];
                    if (axis_distance(dev) > axis_distance(cur))
                        r.sticks[b*8 +: 8] = dev;
                end
                for (int b = 0; b < 2; b++)
                begin
                    if (seat_trig[i][b*8 +: 8] > r.triggers[b*8 +: 8])
                        r.triggers[b*8 +: 8] = seat_trig[i][b*8 +: 8];
                end
                if (first)
                begin
                    r.lead_addr = seat_addr[i];
                    r.lead_inst = seat_inst[i];
                    first       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic res_t merge_predict(input report_word_t w);
        res_t r;
        int   hit;
        hit = -1;
        if (w.action == ACT_DISCONNECT)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (seat_used[i] && seat_addr[i] == w.addr && seat_inst[i] == w.inst)
                    clear_seat(i);
            return (mode_now == MODE_LATEST) ? neutral_word() : blend_seats();
        end
        if (mode_now == MODE_LATEST)
        begin
            r.dropped   = 1'b0;
            r.buttons   = w.buttons;
            r.keys      = w.keys;
            r.sticks    = w.sticks;
            r.triggers  = w.triggers;
            r.delta_x   = w.delta_x;
            r.delta_y   = w.delta_y;
            r.lead_addr = w.addr;
            r.lead_inst = w.inst;
            return r;
        end
        for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
            if (seat_used[i] && seat_addr[i] == w.addr && seat_inst[i] == w.inst)
                hit = i;
        for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
        begin
            if (!seat_used[i])
            begin
                hit          = i;
                seat_used[i] = 1'b1;
                seat_addr[i] = w.addr;
                seat_inst[i] = w.inst;
            end
        end
        if (hit < 0)
        begin
            r         = blend_seats();
            r.dropped = 1'b1;
            return r;
        end
        seat_btn[hit]   = w.buttons;
        seat_key[hit]   = w.keys;
        seat_stick[hit] = w.sticks;
        seat_trig[hit]  = w.triggers;
        r               = blend_seats();
        r.delta_x       = w.delta_x;
        r.delta_y       = w.delta_y;
        return r;
    endfunction

    function automatic report_word_t report_word(input logic act, input logic [7:0] addr,
                                                 input logic [7:0] inst,
                                                 input logic [31:0] btn, input logic [31:0] key,
                                                 input logic [31:0] stk, input logic [15:0] trg,
                                                 input logic [7:0] dx, input logic [7:0] dy);
        report_word_t w;
        w.action   = act;
        w.addr     = addr;
        w.inst     = inst;
        w.buttons  = btn;
        w.keys     = key;
        w.sticks   = stk;
        w.triggers = trg;
        w.delta_x  = dx;
        w.delta_y  = dy;
        return w;
    endfunction

    function automatic logic [7:0] rand_axis();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h81;
            4:       return CENTER;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_trigger();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_bitmap();
        if ($urandom_range(0, 2) == 0)
            return 32'd1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    // mostly pool devices reporting and leaving; some stray disconnects and strangers
    function automatic report_word_t random_report();
        report_word_t w;
        int           pick;
        int           p;
        int           s;
        pick = $urandom_range(0, 99);
        p    = $urandom_range(0, POOL_SIZE - 1);
        s    = $urandom_range(0, SLOT_COUNT - 1);
        w    = report_word(ACT_REPORT, pool_addr[p], pool_inst[p], rand_bitmap(), rand_bitmap(),
                           {rand_axis(), rand_axis(), rand_axis(), rand_axis()},
                           {rand_trigger(), rand_trigger()}, 8'($urandom), 8'($urandom));
        if (pick >= 70 && pick < 80)
            w.action = ACT_DISCONNECT;
        else if (pick >= 80 && pick < 90)
        begin
            w.action = ACT_DISCONNECT;
            if (seat_used[s])
            begin
                w.addr = seat_addr[s];
                w.inst = seat_inst[s];
            end
        end
        else if (pick >= 90 && pick < 96)
        begin
            w.action = ACT_DISCONNECT;
            w.addr   = 8'($urandom);
            w.inst   = 8'($urandom);
        end
        else if (pick >= 96)
        begin
            w.addr = 8'($urandom);
            w.inst = 8'($urandom);
        end
        return w;
    endfunction

    task automatic send_report(input report_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rpt_if.valid <= 1'b0;
            @(posedge clk);
        end
        rpt_if.valid        <= 1'b1;
        rpt_if.action       <= w.action;
        rpt_if.bus_addr     <= w.addr;
        rpt_if.instance_req <= w.inst;
        rpt_if.buttons      <= w.buttons;
        rpt_if.keys         <= w.keys;
        rpt_if.stick_axes   <= w.sticks;
        rpt_if.trigger_axes <= w.triggers;
        rpt_if.delta_x      <= w.delta_x;
        rpt_if.delta_y      <= w.delta_y;
        do
            @(posedge clk);
        while (!rpt_if.ready);
        merged_due_q.push_back(merge_predict(w));
    endtask

    task automatic settle();
        rpt_if.valid <= 1'b0;
        while (merged_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wr_data <= m;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now     = m;
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
        end
    endtask

    task automatic check_merged();
        res_t e;
        if (merged_due_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: merged word with nothing due, expected none, actual %h", $time,
                     mrg_if.merged_buttons);
            return;
        end
        e = merged_due_q.pop_front();
        check_field("dropped",         32'(e.dropped),  32'(mrg_if.dropped));
        check_field("merged_buttons",  e.buttons,       mrg_if.merged_buttons);
        check_field("merged_keys",     e.keys,          mrg_if.merged_keys);
        check_field("merged_sticks",   e.sticks,        mrg_if.merged_sticks);
        check_field("merged_triggers", 32'(e.triggers), 32'(mrg_if.merged_triggers));
        check_field("merged_delta_x",  32'(e.delta_x),  32'(mrg_if.merged_delta_x));
        check_field("merged_delta_y",  32'(e.delta_y),  32'(mrg_if.merged_delta_y));
        check_field("lead_addr",       32'(e.lead_addr), 32'(mrg_if.lead_addr));
        check_field("lead_instance",   32'(e.lead_inst),
                    32'($unsigned(mrg_if.lead_instance)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && mrg_if.valid && mrg_if.ready)
            check_merged();
        mrg_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (rpt_if.valid && rpt_if.ready) || (mrg_if.valid && mrg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_blend_basics();
        send_report(report_word(ACT_DISCONNECT, 8'h05, 8'h03, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_REPORT, 8'h00, 8'h00, 32'h0000_0001, 32'h8000_0000,
                                32'h00FF_7F81, 16'h00FF, 8'h80, 8'h7F));
        // equal distances: lower slot keeps the axis
        send_report(report_word(ACT_REPORT, 8'hFF, 8'h80, 32'h8000_0000, 32'h0000_0001,
                                32'hFF00_817F, 16'hFF00, 8'hFF, 8'h00));
        send_report(report_word(ACT_REPORT, 8'hFF, 8'h7F, $urandom, $urandom,
                                {rand_axis(), rand_axis(), rand_axis(), rand_axis()},
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_REPORT, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'h8080_8080, 16'hFFFF, 8'h01, 8'hFF));
    endtask

    task automatic test_table_full();
        for (int d = 1; d <= 5; d++)
            send_report(report_word(ACT_REPORT, 8'(d), 8'(d), rand_bitmap(), rand_bitmap(),
                                    {rand_axis(), rand_axis(), rand_axis(), rand_axis()},
                                    16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_REPORT, 8'hAA, 8'h55, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_REPORT, 8'hFF, 8'h7F, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_DISCONNECT, 8'hFF, 8'h80, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_REPORT, 8'hAA, 8'h55, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_DISCONNECT, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0,
                                16'd0, 8'd0, 8'd0));
        send_report(report_word(ACT_DISCONNECT, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0,
                                16'd0, 8'd0, 8'd0));
        send_report(report_word(ACT_REPORT, 8'h12, INST_NONE, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_latest_mode();
        settle();
        write_mode(MODE_LATEST);
        send_report(report_word(ACT_REPORT, 8'h33, 8'h44, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_DISCONNECT, 8'hAA, 8'h55, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        send_report(report_word(ACT_DISCONNECT, 8'h99, 8'h99, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
        settle();
        write_mode(MODE_BLEND);
        send_report(report_word(ACT_REPORT, 8'h77, 8'h01, $urandom, $urandom, $urandom,
                                16'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        settle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_addr[p] = 8'($urandom);
            pool_inst[p] = 8'($urandom);
        end
        // start from an empty table
        for (int i = 0; i < SLOT_COUNT; i++)
            if (seat_used[i])
                send_report(report_word(ACT_DISCONNECT, seat_addr[i], seat_inst[i], 32'd0,
                                        32'd0, 32'd0, 16'd0, 8'd0, 8'd0));
        for (int n = 0; n < items; n++)
        begin
            if (n == items * 4 / 5)
            begin
                settle();
                write_mode(MODE_LATEST);
            end
            send_report(random_report());
        end
        settle();
        write_mode(MODE_BLEND);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = MODE_BLEND;
        rpt_if.valid        = 1'b0;
        rpt_if.action       = ACT_REPORT;
        rpt_if.bus_addr     = '0;
        rpt_if.instance_req = '0;
        rpt_if.buttons      = '0;
        rpt_if.keys         = '0;
        rpt_if.stick_axes   = '0;
        rpt_if.trigger_axes = '0;
        rpt_if.delta_x      = '0;
        rpt_if.delta_y      = '0;
        mrg_if.ready        = 1'b0;
        mode_now            = MODE_BLEND;
        for (int i = 0; i < SLOT_COUNT; i++)
            clear_seat(i);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blend_basics();
        test_table_full();
        test_latest_mode();
        test_random(350, 0, 0);
        test_random(350, 64, 0);
        test_random(350, 0, 64);
        test_random(350, 13, 13);
        settle();

        if (mismatches == 0 && merged_due_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/crbm_pkg.sv
src/crbm_if.sv
src/crbm_cell.sv
src/controller_report_blend_merger.sv
tb/sv/controller_report_blend_merger_tb.sv
